// ===== sv/sgsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_pkg
// Action codes and controller/datapath interface types for the slot map.
// ----------------------------------------------------------------------------
package sgsm_pkg;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_MOVE   = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch the input beat
        logic clear_wr;   // clearing pass: write empty at the cell counter
        logic sweep_start;// zero the cell counters
        logic sweep_step; // issue the read of the current cell and advance
        logic look_rd;    // read the cell at the lookup point
        logic flip;       // swap banks, take new origin on a move
        logic load_out;   // load the result register
    } cmd_t;

    // status back to the controller
    typedef struct packed {
        logic last_cell;  // cell counter on the final cell
        logic out_free;   // result register can take a new beat
    } sts_t;

endpackage

// ===== sv/sgsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_ctrl
// Sequencer: clearing pass, lookup read, cell sweeps and result hand-off.
// ----------------------------------------------------------------------------
module sgsm_ctrl
    import sgsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] action,
    output logic       in_stall,
    output cmd_t       cmd,
    input  sts_t       sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LREAD = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.last_cell)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (action == ACT_LOOKUP)
                        state_next = S_LREAD;
                    else
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = S_SWEEP;
                    end
                end
            end
            S_LREAD:
            begin
                cmd.look_rd = 1'b1;
                state_next  = S_DONE;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.last_cell)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                cmd.flip   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/sgsm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_datapath
// Two-bank cell memory, window arithmetic, cell counters and result register.
// ----------------------------------------------------------------------------
module sgsm_datapath
    import sgsm_pkg::*;
#(
    parameter int GRID_SIDE  = 8,
    parameter int SLOT_COUNT = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [1:0]         action,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [9:0]         slot_number,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [10:0] slot_found,
    output logic               outside_window,
    output logic               overflow
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AXIS_W = $clog2(GRID_SIDE);
    localparam int IDX_W  = $clog2(CELLS);
    localparam int CELL_W = $clog2(SLOT_COUNT) + 1;
    localparam int ADDR_W = IDX_W + 1;
    localparam logic signed [CELL_W-1:0] TOP   = CELL_W'(SLOT_COUNT - 1);
    localparam logic signed [CELL_W-1:0] EMPTY = '1;

    function automatic logic [IDX_W-1:0] cell_index(input logic [AXIS_W-1:0] ax,
                                                     input logic [AXIS_W-1:0] ay,
                                                     input logic [AXIS_W-1:0] az);
        cell_index = IDX_W'(ax) * IDX_W'(GRID_SIDE * GRID_SIDE)
                   + IDX_W'(ay) * IDX_W'(GRID_SIDE) + IDX_W'(az);
    endfunction

    // latched item and window state
    logic [1:0]               action_reg;
    logic [31:0]              px_reg, py_reg, pz_reg;
    logic signed [CELL_W-1:0] slot_reg;
    logic [32:0]              dx_reg, dy_reg, dz_reg;
    logic [31:0]              ox_reg, oy_reg, oz_reg;
    logic                     bank_reg;
    logic                     ovf_reg;

    // cell counters
    logic [IDX_W-1:0]  ci_reg;
    logic [AXIS_W-1:0] cx_reg, cy_reg, cz_reg;

    // second pipeline stage of the sweep
    logic              pv_reg;
    logic [IDX_W-1:0]  pidx_reg;
    logic              ppt_reg;
    logic              psrc_reg;

    // memory
    logic signed [CELL_W-1:0] mem [0:(2**ADDR_W)-1];
    logic signed [CELL_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]        raddr, waddr;
    logic signed [CELL_W-1:0] wdata;
    logic                     re, we;

    logic                     slot_big;
    logic signed [CELL_W-1:0] slot_clamped;
    logic                     pt_in;
    logic [IDX_W-1:0]         pt_idx;
    logic [33:0]              sx, sy, sz;
    logic                     src_in;
    logic [IDX_W-1:0]         src_idx;
    logic                     inc_hit, inc_sat;
    logic                     step;

    // clamp the slot to the list
    assign slot_big     = (32'(slot_number) > 32'(SLOT_COUNT - 1));
    assign slot_clamped = slot_big ? TOP : CELL_W'(slot_number);

    // lookup / add point against the window
    assign pt_in  = !dx_reg[32] && (dx_reg[31:0] < 32'(GRID_SIDE))
                 && !dy_reg[32] && (dy_reg[31:0] < 32'(GRID_SIDE))
                 && !dz_reg[32] && (dz_reg[31:0] < 32'(GRID_SIDE));
    assign pt_idx = cell_index(dx_reg[AXIS_W-1:0], dy_reg[AXIS_W-1:0], dz_reg[AXIS_W-1:0]);

    // move source cell for the current destination
    assign sx      = {dx_reg[32], dx_reg} + 34'(cx_reg);
    assign sy      = {dy_reg[32], dy_reg} + 34'(cy_reg);
    assign sz      = {dz_reg[32], dz_reg} + 34'(cz_reg);
    assign src_in  = !sx[33] && (sx[32:0] < 33'(GRID_SIDE))
                  && !sy[33] && (sy[32:0] < 33'(GRID_SIDE))
                  && !sz[33] && (sz[32:0] < 33'(GRID_SIDE));
    assign src_idx = cell_index(sx[AXIS_W-1:0], sy[AXIS_W-1:0], sz[AXIS_W-1:0]);

    assign sts.last_cell = (ci_reg == IDX_W'(CELLS - 1));
    assign sts.out_free  = !out_valid || !out_stall;

    // read port: active bank
    always_comb
    begin
        re    = cmd.look_rd || cmd.sweep_step;
        raddr = {bank_reg, ci_reg};
        if (cmd.look_rd)
            raddr = {bank_reg, pt_idx};
        else if (action_reg == ACT_MOVE)
            raddr = {bank_reg, src_idx};
    end

    // new cell value, written to the other bank; the clearing pass writes empty into the live bank
    assign inc_hit = (rdata_reg >= slot_reg);
    assign inc_sat = inc_hit && (rdata_reg >= TOP);

    always_comb
    begin
        we    = pv_reg || cmd.clear_wr;
        waddr = {~bank_reg, pidx_reg};
        wdata = rdata_reg;
        if (cmd.clear_wr)
        begin
            waddr = {bank_reg, ci_reg};
            wdata = EMPTY;
        end
        else
        begin
            case (action_reg)
                ACT_ADD:
                begin
                    if (ppt_reg)
                        wdata = slot_reg;
                    else if (inc_sat)
                        wdata = TOP;
                    else if (inc_hit)
                        wdata = rdata_reg + CELL_W'(1);
                end
                ACT_DELETE:
                begin
                    if (rdata_reg == slot_reg)
                        wdata = EMPTY;
                    else if (rdata_reg > slot_reg)
                        wdata = rdata_reg - CELL_W'(1);
                end
                ACT_MOVE:
                    wdata = psrc_reg ? rdata_reg : EMPTY;
                default:
                    wdata = rdata_reg;
            endcase
        end
    end

    // cell memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // latched item and sweep stage registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= action;
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            pz_reg     <= pos_z;
            slot_reg   <= slot_clamped;
            dx_reg     <= {pos_x[31], pos_x} - {ox_reg[31], ox_reg};
            dy_reg     <= {pos_y[31], pos_y} - {oy_reg[31], oy_reg};
            dz_reg     <= {pos_z[31], pos_z} - {oz_reg[31], oz_reg};
        end
        if (cmd.sweep_step)
        begin
            pidx_reg <= ci_reg;
            ppt_reg  <= pt_in && (ci_reg == pt_idx);
            psrc_reg <= src_in;
        end
    end

    assign step = cmd.sweep_step || cmd.clear_wr;

    // control state: counters, sweep valid, bank, origin, overflow, result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            pv_reg    <= 1'b0;
            bank_reg  <= 1'b0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            oz_reg    <= '0;
            ovf_reg   <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.sweep_step;
            if (cmd.sweep_start)
            begin
                ci_reg <= '0;
                cx_reg <= '0;
                cy_reg <= '0;
                cz_reg <= '0;
            end
            else if (step)
            begin
                ci_reg <= ci_reg + IDX_W'(1);
                if (cz_reg == AXIS_W'(GRID_SIDE - 1))
                begin
                    cz_reg <= '0;
                    if (cy_reg == AXIS_W'(GRID_SIDE - 1))
                    begin
                        cy_reg <= '0;
                        cx_reg <= cx_reg + AXIS_W'(1);
                    end
                    else
                        cy_reg <= cy_reg + AXIS_W'(1);
                end
                else
                    cz_reg <= cz_reg + AXIS_W'(1);
            end
            // saturation seen during an add sweep
            if (cmd.accept)
                ovf_reg <= 1'b0;
            else if (pv_reg && action_reg == ACT_ADD && inc_sat)
                ovf_reg <= 1'b1;
            // end of sweep: new bank live, new origin on a move
            if (cmd.flip)
            begin
                bank_reg <= ~bank_reg;
                if (action_reg == ACT_MOVE)
                begin
                    ox_reg <= px_reg;
                    oy_reg <= py_reg;
                    oz_reg <= pz_reg;
                end
            end
            if (cmd.load_out)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            slot_found     <= (action_reg == ACT_LOOKUP && pt_in) ? 11'(rdata_reg) : '1;
            outside_window <= (action_reg == ACT_LOOKUP || action_reg == ACT_ADD) && !pt_in;
            overflow       <= (action_reg == ACT_ADD) && ovf_reg;
        end
    end

endmodule

// ===== sv/sliding_grid_slot_map_top.sv =====
`timescale 1ns / 1ps
// Lookup: the item is latched, the cell is read into the read data register, then the
// result register is loaded. Add, delete and move sweep every cell, one cell a cycle on
// the one read and one write port of the two-bank cell memory, then flip the banks and
// load the result. One item at a time: the next beat is taken once the result is loaded.
// Reset: origin 0, then a clearing pass over every cell empties the live bank
// with in_stall held high.
// ----------------------------------------------------------------------------
// sliding_grid_slot_map_top
// Sliding cubic window of slot numbers with lookup, add, delete and move.
// ----------------------------------------------------------------------------
module sliding_grid_slot_map_top
    import sgsm_pkg::*;
#(
    parameter int GRID_SIDE  = 8,
    parameter int SLOT_COUNT = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [9:0]         slot_number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [10:0] slot_found,
    output logic               outside_window,
    output logic               overflow
);

    cmd_t cmd;
    sts_t sts;

    sgsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    sgsm_datapath #(
        .GRID_SIDE  (GRID_SIDE),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .action         (action),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .slot_number    (slot_number),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .slot_found     (slot_found),
        .outside_window (outside_window),
        .overflow       (overflow)
    );

endmodule

// ===== sv/sgsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_checker
// Port-level checks on the slot map, bound to the top level.
// ----------------------------------------------------------------------------
module sgsm_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [10:0] slot_found,
    input logic               outside_window,
    input logic               overflow
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot_found)
                                   && $stable(outside_window) && $stable(overflow))
        else $error("result beat changed under stall");

    // one item at a time: busy straight after an accepted beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in progress");

    // a found slot only comes from an inside lookup
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (slot_found != -11'sd1) |-> !outside_window && !overflow)
        else $error("found slot with outside or overflow flag");

    // an outside point never reports a slot
    a_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outside_window |-> slot_found == -11'sd1)
        else $error("outside point reported a slot");

endmodule

bind sliding_grid_slot_map_top sgsm_checker u_sgsm_checker (.*);
